@@ rtl/cpd_pkg.sv @@
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int DIST_W       = 17;
    localparam int CMP_W        = (DIFF_W > DIST_W) ? DIFF_W : DIST_W;
    localparam int SQ_W         = 2 * DIST_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int CNT_W        = $clog2(ROOT_W);
    localparam int DIM_W        = 2;

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [DIM_W-1:0]  DIMS_ONE   = 2'd1;
    localparam logic [DIM_W-1:0]  DIMS_TWO   = 2'd2;
    localparam logic [DIM_W-1:0]  DIMS_THREE = 2'd3;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        t_axis mul_sel;
        logic  acc_en;
        logic  root_init;
        logic  root_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

@@ rtl/cpd_if.sv @@
`timescale 1ns / 1ps

interface cpd_in_if;
    logic              valid;
    logic              ready;
    cpd_pkg::t_sample  coord_x;
    cpd_pkg::t_sample  coord_y;
    cpd_pkg::t_sample  coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface cpd_out_if;
    logic                         valid;
    logic                         ready;
    logic [cpd_pkg::DIST_W-1:0]   distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

@@ rtl/cpd_ctrl.sv @@
`timescale 1ns / 1ps

module cpd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  cpd_pkg::t_stat i_stat,
    output cpd_pkg::t_cmd  o_cmd
);

    cpd_pkg::t_state                r_state;
    cpd_pkg::t_state                n_state;
    logic [cpd_pkg::CNT_W-1:0]      r_cnt;
    logic [cpd_pkg::CNT_W-1:0]      n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = cpd_pkg::AXIS_X;
        unique case (r_state)
            cpd_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = cpd_pkg::ST_SQUARE;
                end
            end
            cpd_pkg::ST_SQUARE: begin
                // multiply one axis per cycle, accumulate each registered product in the next cycle
                o_cmd.mul_en = (r_cnt != cpd_pkg::SQ_LAST);
                o_cmd.acc_en = (r_cnt != '0);
                unique case (r_cnt[1:0])
                    2'd1:    o_cmd.mul_sel = cpd_pkg::AXIS_Y;
                    2'd2:    o_cmd.mul_sel = cpd_pkg::AXIS_Z;
                    default: o_cmd.mul_sel = cpd_pkg::AXIS_X;
                endcase
                if (r_cnt == cpd_pkg::SQ_LAST) begin
                    n_state = cpd_pkg::ST_ROOT_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cpd_pkg::ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = cpd_pkg::ST_ROOT;
            end
            cpd_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == cpd_pkg::ROOT_LAST) begin
                    n_state = cpd_pkg::ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cpd_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cpd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cpd_dp.sv @@
`timescale 1ns / 1ps

module cpd_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cpd_pkg::DIM_W-1:0]    i_cfg_wdata,
    input  cpd_pkg::t_sample             i_coord_x,
    input  cpd_pkg::t_sample             i_coord_y,
    input  cpd_pkg::t_sample             i_coord_z,
    input  cpd_pkg::t_cmd                i_cmd,
    output cpd_pkg::t_stat               o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [cpd_pkg::DIST_W-1:0]   o_distance
);

    logic [cpd_pkg::DIM_W-1:0]   r_dims;
    cpd_pkg::t_sample            r_prev_x;
    cpd_pkg::t_sample            r_prev_y;
    cpd_pkg::t_sample            r_prev_z;
    logic [cpd_pkg::DIST_W-1:0]  r_dx;
    logic [cpd_pkg::DIST_W-1:0]  r_dy;
    logic [cpd_pkg::DIST_W-1:0]  r_dz;
    logic                        r_sat;
    logic [cpd_pkg::SQ_W-1:0]    r_prod;
    logic [cpd_pkg::SUM_W-1:0]   r_acc;
    logic [cpd_pkg::SUM_W-1:0]   r_rad;
    logic [cpd_pkg::REM_W-1:0]   r_rem;
    logic [cpd_pkg::ROOT_W-1:0]  r_root;
    logic                        r_out_valid;
    logic [cpd_pkg::DIST_W-1:0]  r_out;

    logic                        use_y;
    logic                        use_z;
    logic [cpd_pkg::CMP_W-1:0]   dx_full;
    logic [cpd_pkg::CMP_W-1:0]   dy_full;
    logic [cpd_pkg::CMP_W-1:0]   dz_full;
    logic                        any_sat;
    logic [cpd_pkg::DIST_W-1:0]  mul_op;
    logic [cpd_pkg::REM_W-1:0]   trial;
    logic [cpd_pkg::REM_W-1:0]   test;
    logic                        root_big;

    function automatic logic [cpd_pkg::CMP_W-1:0] abs_diff(
        input cpd_pkg::t_sample a,
        input cpd_pkg::t_sample b
    );
        logic signed [cpd_pkg::DIFF_W-1:0] d;
        d = cpd_pkg::DIFF_W'(a) - cpd_pkg::DIFF_W'(b);
        if (d < 0) begin
            d = -d;
        end
        return cpd_pkg::CMP_W'(unsigned'(d));
    endfunction

    assign use_y   = (r_dims == cpd_pkg::DIMS_TWO) || (r_dims == cpd_pkg::DIMS_THREE);
    assign use_z   = (r_dims == cpd_pkg::DIMS_THREE);
    assign dx_full = abs_diff(i_coord_x, r_prev_x);
    assign dy_full = use_y ? abs_diff(i_coord_y, r_prev_y) : '0;
    assign dz_full = use_z ? abs_diff(i_coord_z, r_prev_z) : '0;
    assign any_sat = (dx_full > cpd_pkg::CMP_W'(cpd_pkg::DIST_MAX))
                  || (dy_full > cpd_pkg::CMP_W'(cpd_pkg::DIST_MAX))
                  || (dz_full > cpd_pkg::CMP_W'(cpd_pkg::DIST_MAX));

    always_comb begin
        unique case (i_cmd.mul_sel)
            cpd_pkg::AXIS_Y: mul_op = r_dy;
            cpd_pkg::AXIS_Z: mul_op = r_dz;
            default:         mul_op = r_dx;
        endcase
    end

    assign trial    = {r_rem[cpd_pkg::REM_W-3:0], r_rad[cpd_pkg::SUM_W-1 -: 2]};
    assign test     = cpd_pkg::REM_W'({r_root, 2'b01});
    assign root_big = r_sat || (r_root > cpd_pkg::ROOT_W'(cpd_pkg::DIST_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims      <= cpd_pkg::DIMS_ONE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_prev_x <= i_coord_x;
                if (use_y) begin
                    r_prev_y <= i_coord_y;
                end
                if (use_z) begin
                    r_prev_z <= i_coord_z;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx  <= dx_full[cpd_pkg::DIST_W-1:0];
            r_dy  <= dy_full[cpd_pkg::DIST_W-1:0];
            r_dz  <= dz_full[cpd_pkg::DIST_W-1:0];
            r_sat <= any_sat;
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + cpd_pkg::SUM_W'(r_prod);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_op * mul_op;
        end
        if (i_cmd.root_init) begin
            r_rad  <= r_acc;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
            if (trial >= test) begin
                r_rem  <= trial - test;
                r_root <= {r_root[cpd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= trial;
                r_root <= {r_root[cpd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out <= root_big ? cpd_pkg::DIST_MAX : r_root[cpd_pkg::DIST_W-1:0];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_distance      = r_out;

endmodule

@@ rtl/consecutive_point_distance_unit.sv @@
`timescale 1ns / 1ps
// Per request: square and accumulate the axis differences, root set-up, 18 root
// iterations at one bit per cycle, then the output load once the output is free.
// A new request is accepted only after the previous result has been loaded.
// Reset (synchronous, active low): previous point to the origin, dimensions to 1,
// no result pending.

module consecutive_point_distance_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cpd_pkg::DIM_W-1:0]  i_cfg_wdata,
    cpd_in_if.sink                     i_point,
    cpd_out_if.source                  o_dist
);

    cpd_pkg::t_cmd   cmd;
    cpd_pkg::t_stat  stat;
    logic            req_ready;

    cpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_point.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_coord_x   (i_point.coord_x),
        .i_coord_y   (i_point.coord_y),
        .i_coord_z   (i_point.coord_z),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_dist.ready),
        .o_out_valid (o_dist.valid),
        .o_distance  (o_dist.distance)
    );

    assign i_point.ready = req_ready;

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_point.valid && i_point.ready |=> !i_point.ready)
        else $error("request accepted while previous one still in progress");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("pending result overwritten");

    a_mul_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_en || cmd.root_step |-> !i_point.ready)
        else $error("datapath active while controller idle");

    a_load_only_on_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> i_point.valid && i_point.ready)
        else $error("point loaded without an accepted request");
`endif

endmodule
